// ===== sv/ired_pkg.sv =====
// Shared types, constants and register map of the IR edge timing decoder.
package ired_pkg;

   localparam int TIME_BITS   = 32;
   localparam int CFG_BITS    = 32;
   localparam int CMP_BITS    = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
   localparam int COUNT_BITS  = 7;
   localparam int CODE_BITS   = 16;
   localparam int STATUS_BITS = 2;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 32;
   localparam int FRAME_BITS  = 32;
   localparam int POS_BITS    = $clog2(FRAME_BITS);

   // Edge positions within a frame
   localparam int FRAME_EDGES    = 68;
   localparam int LEAD_EDGE      = 1;
   localparam int SPACE_EDGE     = 2;
   localparam int REPEAT_EDGES   = 4;
   localparam int FIRST_BIT_EDGE = 4;
   localparam int LAST_BIT_EDGE  = FRAME_EDGES - 2;

   // Register reset values, in ticks
   localparam logic [CFG_BITS-1:0] TIMEOUT_RESET      = CFG_BITS'(30000);
   localparam logic [CFG_BITS-1:0] LEAD_MIN_RESET     = CFG_BITS'(8000);
   localparam logic [CFG_BITS-1:0] LEAD_MAX_RESET     = CFG_BITS'(10000);
   localparam logic [CFG_BITS-1:0] REPEAT_SPACE_RESET = CFG_BITS'(3000);
   localparam logic [CFG_BITS-1:0] ONE_THRESH_RESET   = CFG_BITS'(1000);

   typedef enum logic [2:0] {
      REG_TIMEOUT      = 3'd0,
      REG_LEAD_MIN     = 3'd1,
      REG_LEAD_MAX     = 3'd2,
      REG_REPEAT_SPACE = 3'd3,
      REG_ONE_THRESH   = 3'd4
   } reg_index_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_NEW         = 2'd0,
      STATUS_REPEAT      = 2'd1,
      STATUS_CHECK_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] timeout_ticks;
      logic [CFG_BITS-1:0] lead_min_ticks;
      logic [CFG_BITS-1:0] lead_max_ticks;
      logic [CFG_BITS-1:0] repeat_space_max;
      logic [CFG_BITS-1:0] one_threshold;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [CODE_BITS-1:0] key_code;
      status_type           status;
   } result_type;

endpackage

// ===== sv/ired_if.sv =====
// Handshake channel interfaces for edge transactions and decoded results.
interface ired_req_if
   import ired_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] edge_time;

   modport source (output valid, output edge_time, input ready);
   modport sink   (input valid, input edge_time, output ready);
endinterface

interface ired_rsp_if
   import ired_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CODE_BITS-1:0]   key_code;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output key_code, output status, input ready);
   modport sink   (input valid, input key_code, input status, output ready);
endinterface

// ===== sv/ired_csr.sv =====
// APB-style register file holding the decoder's timing thresholds.
module ired_csr
   import ired_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = reg_index_type'(paddr[ADDR_BITS-1:2]);
   assign write_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_TIMEOUT:      cfg_in.timeout_ticks    = pwdata;
            REG_LEAD_MIN:     cfg_in.lead_min_ticks   = pwdata;
            REG_LEAD_MAX:     cfg_in.lead_max_ticks   = pwdata;
            REG_REPEAT_SPACE: cfg_in.repeat_space_max = pwdata;
            REG_ONE_THRESH:   cfg_in.one_threshold    = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_TIMEOUT:      prdata = cfg_ff.timeout_ticks;
         REG_LEAD_MIN:     prdata = cfg_ff.lead_min_ticks;
         REG_LEAD_MAX:     prdata = cfg_ff.lead_max_ticks;
         REG_REPEAT_SPACE: prdata = cfg_ff.repeat_space_max;
         REG_ONE_THRESH:   prdata = cfg_ff.one_threshold;
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks    <= TIMEOUT_RESET;
         cfg_ff.lead_min_ticks   <= LEAD_MIN_RESET;
         cfg_ff.lead_max_ticks   <= LEAD_MAX_RESET;
         cfg_ff.repeat_space_max <= REPEAT_SPACE_RESET;
         cfg_ff.one_threshold    <= ONE_THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/ired_core.sv =====
// Frame state and per-edge decode: gap timing, bit collection, code check.
module ired_core
   import ired_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [TIME_BITS-1:0] edge_time,
   input  cfg_type              cfg,
   output result_type           result
);

   logic [COUNT_BITS-1:0] edge_count_ff, edge_count_in;
   logic [TIME_BITS-1:0]  prev_time_ff,  prev_time_in;
   logic                  lead_ok_ff,    lead_ok_in;
   logic                  short_ff,      short_in;
   logic [FRAME_BITS-1:0] frame_ff,      frame_in;
   logic [CODE_BITS-1:0]  last_code_ff,  last_code_in;

   logic [TIME_BITS-1:0]  gap;
   logic [CMP_BITS-1:0]   gap_x;
   logic [COUNT_BITS-1:0] cnt;
   logic [COUNT_BITS-1:0] bit_offset;
   logic [POS_BITS-1:0]   pos;
   logic                  timed_out;
   logic                  bit_edge;
   logic [7:0]            addr, naddr, cmd, ncmd;

   assign gap        = edge_time - prev_time_ff;
   assign gap_x      = CMP_BITS'(gap);
   assign cnt        = edge_count_ff + COUNT_BITS'(1);
   assign bit_offset = edge_count_ff - COUNT_BITS'(FIRST_BIT_EDGE);
   assign pos        = bit_offset[POS_BITS:1];
   assign timed_out  = (edge_count_ff != '0) && (gap_x > CMP_BITS'(cfg.timeout_ticks));
   assign bit_edge   = (edge_count_ff >= COUNT_BITS'(FIRST_BIT_EDGE)) && !edge_count_ff[0]
                       && (edge_count_ff <= COUNT_BITS'(LAST_BIT_EDGE));

   assign addr  = frame_in[7:0];
   assign naddr = frame_in[15:8];
   assign cmd   = frame_in[23:16];
   assign ncmd  = frame_in[31:24];

   always_comb begin
      edge_count_in   = edge_count_ff;
      prev_time_in    = prev_time_ff;
      lead_ok_in      = lead_ok_ff;
      short_in        = short_ff;
      frame_in        = frame_ff;
      last_code_in    = last_code_ff;
      result.valid    = 1'b0;
      result.key_code = '0;
      result.status   = STATUS_NEW;
      if (fire) begin
         prev_time_in = edge_time;
         if (timed_out) begin
            // restart: this edge becomes edge 0 of a new frame
            edge_count_in = COUNT_BITS'(1);
         end else begin
            edge_count_in = cnt;
            if (edge_count_ff == COUNT_BITS'(LEAD_EDGE)) begin
               lead_ok_in = (gap_x > CMP_BITS'(cfg.lead_min_ticks))
                            && (gap_x < CMP_BITS'(cfg.lead_max_ticks));
            end else if (edge_count_ff == COUNT_BITS'(SPACE_EDGE)) begin
               short_in = gap_x < CMP_BITS'(cfg.repeat_space_max);
            end else if (bit_edge) begin
               frame_in[pos] = gap_x > CMP_BITS'(cfg.one_threshold);
            end

            if ((cnt == COUNT_BITS'(REPEAT_EDGES)) && lead_ok_ff && short_ff) begin
               edge_count_in   = '0;
               result.valid    = 1'b1;
               result.key_code = last_code_ff;
               result.status   = STATUS_REPEAT;
            end else if (cnt >= COUNT_BITS'(FRAME_EDGES)) begin
               edge_count_in = '0;
               result.valid  = 1'b1;
               if ((addr != ~naddr) || (cmd != ~ncmd)) begin
                  result.status = STATUS_CHECK_ERROR;
               end else begin
                  last_code_in    = {addr, cmd};
                  result.key_code = {addr, cmd};
                  result.status   = STATUS_NEW;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         prev_time_ff  <= '0;
         lead_ok_ff    <= 1'b0;
         short_ff      <= 1'b0;
         frame_ff      <= '0;
         last_code_ff  <= '0;
      end else begin
         edge_count_ff <= edge_count_in;
         prev_time_ff  <= prev_time_in;
         lead_ok_ff    <= lead_ok_in;
         short_ff      <= short_in;
         frame_ff      <= frame_in;
         last_code_ff  <= last_code_in;
      end
   end

endmodule

// ===== sv/ir_edge_timing_decoder.sv =====
// Top level of the IR edge timing decoder: input and result registers around the decode core.
//
// Use: feed one transaction on req_bus per receiver-pin edge (either polarity),
// carrying the free-running tick count at that edge in edge_time. The block
// times each gap against the previous edge, collects 32 bits LSB first and
// returns zero or one transaction on rsp_bus: a new key code, a repeat of the
// last good code, or an inverse check error (key_code zero).
// Thresholds sit in five 32-bit registers on the csr_ APB port at 4*index;
// write them only while no edge is in flight. csr_pready is always high.
// Path: an accepted edge is registered in the input register, decoded by the core once
// the result slot is free, and its result registered for rsp_bus. Throughput: one edge
// per cycle while the result slot is free, as the core updates its frame state per edge.
// Reset (synchronous, active high) clears the frame state, the last code and
// both pipeline registers, and loads the default thresholds.
// Stall: while a result waits on rsp_bus the pending edge holds in the input
// register and req_bus.ready drops once that register is full.
module ir_edge_timing_decoder
   import ired_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   ired_req_if.sink             req_bus,
   ired_rsp_if.source           rsp_bus,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   cfg_type              cfg;
   result_type           result;

   logic                 in_valid_ff, in_valid_in;
   logic [TIME_BITS-1:0] in_time_ff,  in_time_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CODE_BITS-1:0] out_code_ff,  out_code_in;
   status_type           out_status_ff, out_status_in;

   logic                 advance;
   logic                 req_take;

   ired_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Advance the edge register into the core whenever the result slot is free
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   ired_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (in_valid_ff && advance),
      .edge_time (in_time_ff),
      .cfg       (cfg),
      .result    (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_time_in  = in_time_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_time_in  = req_bus.edge_time;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_code_in   = out_code_ff;
      out_status_in = out_status_ff;
      if (advance) begin
         // load a fresh result, or drop the one just taken
         out_valid_in  = result.valid;
         out_code_in   = result.key_code;
         out_status_in = result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         in_time_ff    <= '0;
         out_code_ff   <= '0;
         out_status_ff <= STATUS_NEW;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         in_time_ff    <= in_time_in;
         out_code_ff   <= out_code_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.key_code = out_code_ff;
   assign rsp_bus.status   = out_status_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the IR edge timing decoder: edge stimulus, decode prediction, checks.
`timescale 1ns / 100ps

module tb_top;
   import ired_pkg::*;

   // Bench constants
   localparam int LIMIT_CYCLES = 400000;  // watchdog limit for the whole run
   localparam int DRAIN_CYCLES = 8;       // settling after the last key is back
   localparam int PHASE_ITEMS  = 16;
   localparam logic [CFG_BITS-1:0] TICKS_MAX = '1;

   typedef struct {
      logic [CODE_BITS-1:0] key_code;
      status_type           status;
   } decoded_key_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Channels and register port
   ired_req_if req_bus ();
   ired_rsp_if rsp_bus ();

   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [DATA_BITS-1:0] csr_pwdata;
   logic [DATA_BITS-1:0] csr_prdata;
   logic                 csr_pready;

   ir_edge_timing_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Decoder shadow: thresholds and frame state as the block should hold them
   cfg_type                 thresholds = '{TIMEOUT_RESET, LEAD_MIN_RESET, LEAD_MAX_RESET,
                                           REPEAT_SPACE_RESET, ONE_THRESH_RESET};
   logic [COUNT_BITS-1:0]   frame_edge_cnt  = '0;
   logic [TIME_BITS-1:0]    last_edge_time  = '0;
   logic                    lead_seen_ok    = 1'b0;
   logic                    space_was_short = 1'b0;
   logic [FRAME_BITS-1:0]   bit_store       = '0;
   logic [CODE_BITS-1:0]    good_code       = '0;

   decoded_key_type         expected_keys[$];

   // Bench bookkeeping
   int                      fail_count     = 0;
   int                      items_sent     = 0;
   int                      cycle_count    = 0;
   int                      tx_idle_pct    = 0;
   int                      rx_idle_pct    = 0;
   int                      hold_request   = 0;
   logic [TIME_BITS-1:0]    edge_clock     = '0;

   // Advance the shadow by one accepted edge; report the key it yields, if any.
   function automatic void decode_edge(input logic [TIME_BITS-1:0] stamp, output bit produced,
                                       output logic [CODE_BITS-1:0] key, output status_type st);
      logic [TIME_BITS-1:0] gap;
      int                   k;
      int                   cnt;
      logic [POS_BITS-1:0]  pos;
      logic [7:0]           addr;
      logic [7:0]           naddr;
      logic [7:0]           cmd;
      logic [7:0]           ncmd;
      produced = 1'b0;
      key      = '0;
      st       = STATUS_NEW;
      gap      = stamp - last_edge_time;  // wraps modulo the tick counter width
      k        = frame_edge_cnt;
      cnt      = k + 1;

      // A long silence mid-frame turns this edge into the first of a new frame
      if (cnt >= 2 && gap > thresholds.timeout_ticks) begin
         last_edge_time = stamp;
         frame_edge_cnt = COUNT_BITS'(1);
         return;
      end

      if (k == LEAD_EDGE) begin
         lead_seen_ok = (gap > thresholds.lead_min_ticks) && (gap < thresholds.lead_max_ticks);
      end else if (k == SPACE_EDGE) begin
         space_was_short = gap < thresholds.repeat_space_max;
      end else if (k >= FIRST_BIT_EDGE && k[0] == 1'b0 && k <= LAST_BIT_EDGE) begin
         pos            = POS_BITS'((k - FIRST_BIT_EDGE) >> 1);
         bit_store[pos] = gap > thresholds.one_threshold;
      end

      last_edge_time = stamp;
      frame_edge_cnt = COUNT_BITS'(cnt);

      if (cnt == REPEAT_EDGES && lead_seen_ok && space_was_short) begin
         frame_edge_cnt = '0;
         produced       = 1'b1;
         key            = good_code;
         st             = STATUS_REPEAT;
         return;
      end

      if (cnt >= FRAME_EDGES) begin
         addr           = bit_store[7:0];
         naddr          = bit_store[15:8];
         cmd            = bit_store[23:16];
         ncmd           = bit_store[31:24];
         frame_edge_cnt = '0;
         produced       = 1'b1;
         if ((addr ^ naddr) != 8'hFF || (cmd ^ ncmd) != 8'hFF) begin
            key = '0;
            st  = STATUS_CHECK_ERROR;
         end else begin
            good_code = {addr, cmd};
            key       = good_code;
            st        = STATUS_NEW;
         end
      end
   endfunction

   function automatic logic [CFG_BITS-1:0] threshold_of(input cfg_type c, input reg_index_type idx);
      case (idx)
         REG_TIMEOUT:      return c.timeout_ticks;
         REG_LEAD_MIN:     return c.lead_min_ticks;
         REG_LEAD_MAX:     return c.lead_max_ticks;
         REG_REPEAT_SPACE: return c.repeat_space_max;
         default:          return c.one_threshold;
      endcase
   endfunction

   function automatic logic [ADDR_BITS-1:0] reg_addr(input reg_index_type idx);
      return ADDR_BITS'(idx) << 2;
   endfunction

   // Watchdog: end the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result check and edge capture, both sampled at the rising edge
   always @(posedge clock) begin : result_check
      decoded_key_type      want;
      bit                   got;
      logic [CODE_BITS-1:0] key;
      status_type           st;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_keys.size() == 0) begin
               $error("unexpected result: key_code %h, status %0d",
                      rsp_bus.key_code, rsp_bus.status);
               fail_count++;
            end else begin
               want = expected_keys.pop_front();
               if (rsp_bus.key_code !== want.key_code) begin
                  $error("key_code: expected %h, actual %h", want.key_code, rsp_bus.key_code);
                  fail_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                  fail_count++;
               end
            end
         end
         // Predict at acceptance; the result cannot come back in the same cycle
         if (req_bus.valid && req_bus.ready) begin
            decode_edge(req_bus.edge_time, got, key, st);
            if (got) begin
               want.key_code = key;
               want.status   = st;
               expected_keys.push_back(want);
            end
         end
      end
   end

   // Result receiver: random idling, plus long hold-offs on request
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_request > 0) begin
            hold_left    = hold_request - 1;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offer one edge transaction, idling first at random; leave valid high on return
   task automatic send_edge(input logic [TIME_BITS-1:0] stamp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.edge_time <= stamp;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic emit_gap(input longint gap);
      edge_clock = edge_clock + TIME_BITS'(gap);
      send_edge(edge_clock);
   endtask

   task automatic emit_raw(input logic [TIME_BITS-1:0] stamp);
      edge_clock = stamp;
      send_edge(stamp);
   endtask

   // Drop valid and hold until every expected key is back and the pipeline is empty
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access; the register takes the value at the access edge
   task automatic csr_write(input reg_index_type idx, input logic [CFG_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= reg_addr(idx);
      csr_pwdata  <= DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_TIMEOUT:      thresholds.timeout_ticks    = value;
         REG_LEAD_MIN:     thresholds.lead_min_ticks   = value;
         REG_LEAD_MAX:     thresholds.lead_max_ticks   = value;
         REG_REPEAT_SPACE: thresholds.repeat_space_max = value;
         default:          thresholds.one_threshold    = value;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input reg_index_type idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= reg_addr(idx);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== DATA_BITS'(threshold_of(thresholds, idx))) begin
         $error("%s: expected %h, actual %h", idx.name(),
                threshold_of(thresholds, idx), csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Load a full threshold set once the block is quiet, then read it all back
   task automatic set_thresholds(input cfg_type setting);
      reg_index_type idx;
      wait_quiet();
      for (int i = 0; i <= REG_ONE_THRESH; i++) begin
         idx = reg_index_type'(i);
         csr_write(idx, threshold_of(setting, idx));
      end
      for (int i = 0; i <= REG_ONE_THRESH; i++) begin
         idx = reg_index_type'(i);
         csr_read_check(idx);
      end
   endtask

   // Random value in [lo, hi], biased towards both ends; an empty range yields hi (never below 0)
   function automatic longint rand_in(input longint lo, input longint hi);
      longint unsigned spread;
      int              pick;
      pick = $urandom_range(15);
      if (hi < lo) return (hi < 0) ? 0 : hi;
      if (pick == 0) return lo;
      if (pick == 1) return hi;
      spread = hi - lo + 1;
      return lo + longint'({$urandom, $urandom} % spread);
   endfunction

   // Clamp an in-frame gap so that it never trips the timeout
   function automatic longint cap(input longint gap);
      longint tmo;
      tmo = thresholds.timeout_ticks;
      return (gap < tmo) ? gap : tmo;
   endfunction

   // Gap before edge e of a frame or repeat burst, shaped by the current thresholds
   function automatic longint unit_gap(input logic [FRAME_BITS-1:0] word, input int e,
                                       input bit lead_good, input bit repeat_form);
      longint tmo;
      longint lmin;
      longint lmax;
      longint rsm;
      longint one;
      tmo  = thresholds.timeout_ticks;
      lmin = thresholds.lead_min_ticks;
      lmax = thresholds.lead_max_ticks;
      rsm  = thresholds.repeat_space_max;
      one  = thresholds.one_threshold;
      if (e == 0) return rand_in(tmo + 1, tmo + 40000);  // silence: start a fresh frame
      if (e == LEAD_EDGE) begin
         if (lead_good) return rand_in(lmin + 1, cap(lmax - 1));
         if ($urandom_range(1)) return rand_in(lmax, cap(lmax + 3000));
         return rand_in((lmin > 3000) ? lmin - 3000 : 0, cap(lmin));
      end
      if (e == SPACE_EDGE) begin
         if (repeat_form) return rand_in((rsm > 1500) ? rsm - 1500 : 0, cap(rsm - 1));
         return rand_in(rsm, cap(rsm + 3000));
      end
      if (e % 2 == 1) return rand_in(200, cap(1200));  // mark
      if (word[POS_BITS'((e - FIRST_BIT_EDGE) / 2)]) return rand_in(one + 1, cap(one + 2000));
      return rand_in((one > 1500) ? one - 1500 : 0, cap(one));
   endfunction

   task automatic send_burst(input logic [FRAME_BITS-1:0] word, input int edges,
                             input bit lead_good, input bit repeat_form);
      for (int e = 0; e < edges; e++) begin
         emit_gap(unit_gap(word, e, lead_good, repeat_form));
      end
   endtask

   // Mostly well-formed repeats and frames with random content; the rest broken or noise
   task automatic send_random_unit();
      int                    roll;
      logic [7:0]            addr;
      logic [7:0]            cmd;
      logic [FRAME_BITS-1:0] word;
      roll = $urandom_range(99);
      addr = 8'($urandom);
      cmd  = 8'($urandom);
      word = {~cmd, cmd, ~addr, addr};
      if (roll < 45) begin
         send_burst(word, REPEAT_EDGES, $urandom_range(9) != 0, 1'b1);
      end else if (roll < 80) begin
         if ($urandom_range(4) == 0) word ^= 32'h1 << $urandom_range(31);
         send_burst(word, FRAME_EDGES, 1'b1, 1'b0);
      end else if (roll < 90) begin
         // truncated frame, left hanging until the next silence
         send_burst(word, $urandom_range(FRAME_EDGES - 1, 1), $urandom_range(1), 1'b0);
      end else begin
         repeat ($urandom_range(6, 1)) emit_raw($urandom);
      end
   endtask

   function automatic cfg_type random_thresholds();
      cfg_type c;
      c.timeout_ticks    = $urandom_range(60000, 20000);
      c.lead_min_ticks   = $urandom_range(8500, 6000);
      c.lead_max_ticks   = $urandom_range(12000, 9500);
      c.repeat_space_max = $urandom_range(4000, 1500);
      c.one_threshold    = $urandom_range(1500, 600);
      return c;
   endfunction

   // Tests

   task automatic test_register_defaults();
      for (int i = 0; i <= REG_ONE_THRESH; i++) begin
         csr_read_check(reg_index_type'(i));
      end
   endtask

   task automatic test_directed_edges();
      tx_idle_pct = 10;
      rx_idle_pct = 10;
      // first edge near the top of the tick range; the lead then wraps through zero
      emit_raw(32'hFFFF_F000);
      emit_gap(9000);
      emit_gap(2250);
      emit_gap(560);    // repeat before any good frame: key zero
      emit_gap(30000);  // first edge of the next frame
      emit_gap(30000);  // gap equal to the timeout: no restart, lead out of range
      emit_gap(30001);  // one tick over: restart here
      emit_gap(9000);
      emit_gap(4500);
      emit_gap(560);    // long space: no repeat, collection goes on
      emit_gap(1690);
      emit_gap(560);
      emit_raw(32'h0000_0000);  // timeout mid-frame, on a wrapped gap
      emit_raw(32'hFFFF_FFFF);  // timeout again, right after the restart
      emit_raw(32'hFFFF_FFFF);  // zero gap: lead too short
      // lead one over the minimum and space one under the repeat limit
      emit_gap(40000);
      emit_gap(32'd8001);
      emit_gap(32'd2999);
      emit_gap(500);
      // lead exactly at the minimum: no repeat
      emit_gap(40000);
      emit_gap(32'd8000);
      emit_gap(2000);
      emit_gap(500);
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input cfg_type setting);
      int items_at_start;
      set_thresholds(setting);
      tx_idle_pct    = tx_pct;
      rx_idle_pct    = rx_pct;
      items_at_start = items_sent;
      while (items_sent - items_at_start < PHASE_ITEMS) begin
         send_random_unit();
      end
   endtask

   // Hold the receiver off so the pipeline fills and the input stalls
   task automatic test_result_backpressure();
      logic [FRAME_BITS-1:0] word;
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      word         = $urandom;
      hold_request = 150;
      repeat (10) send_burst(word, REPEAT_EDGES, 1'b1, 1'b1);
      wait_quiet();  // sender pauses until every key is back
      word         = {~word[23:16], word[23:16], ~word[7:0], word[7:0]};
      hold_request = 120;
      send_burst(word, FRAME_EDGES, 1'b1, 1'b0);
      repeat (6) send_burst(word, REPEAT_EDGES, 1'b1, 1'b1);
      wait_quiet();
   endtask

   task automatic test_threshold_extremes();
      cfg_type               settings[4];
      logic [FRAME_BITS-1:0] word;
      settings[0] = '{'0, '0, '0, '0, '0};
      settings[1] = '{TICKS_MAX, '0, TICKS_MAX, TICKS_MAX, TICKS_MAX};
      settings[2] = '{TICKS_MAX, '0, TICKS_MAX, '0, '0};
      settings[3] = '{CFG_BITS'(100000), TICKS_MAX, '0, '0, CFG_BITS'(1000)};
      foreach (settings[s]) begin
         set_thresholds(settings[s]);
         tx_idle_pct = 25;
         rx_idle_pct = 25;
         word        = $urandom;
         word        = {~word[23:16], word[23:16], ~word[7:0], word[7:0]};
         send_burst(word, FRAME_EDGES, 1'b1, 1'b0);
         send_burst(word, REPEAT_EDGES, 1'b1, 1'b1);
      end
   endtask

   // Sequence
   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.edge_time <= '0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      reset             <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_directed_edges();
      test_random_traffic(14, 72, '{TIMEOUT_RESET, LEAD_MIN_RESET, LEAD_MAX_RESET,
                                    REPEAT_SPACE_RESET, ONE_THRESH_RESET});
      test_random_traffic(72, 14, random_thresholds());
      test_result_backpressure();
      test_threshold_extremes();
      test_random_traffic(0, 0, random_thresholds());

      // Drain: every key back, then let the pipeline settle
      wait_quiet();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ired_pkg.sv
sv/ired_if.sv
sv/ired_csr.sv
sv/ired_core.sv
sv/ir_edge_timing_decoder.sv
bench/tb_top.sv
